@@ hw/rtl/zar_pkg.sv @@
package zar_pkg;

	localparam int COL_W     = 11;
	localparam int SHIFT_W   = 11;
	localparam int PIX_W     = 8;
	localparam int LEVEL_W   = 8;
	localparam int REG_IDX_W = 3;

	localparam logic [PIX_W-1:0]   ACTIVE_VALUE    = 8'd255;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX       = 8'd255;
	localparam logic [LEVEL_W-1:0] LEVEL_RESET     = 8'd0;
	localparam logic [LEVEL_W-1:0] RAMP_STEP_RESET = 8'd15;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_TICK  = 1'b1
	} op_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ZONE_LEFT   = 3'd0,
		REG_ZONE_TOP    = 3'd1,
		REG_ZONE_RIGHT  = 3'd2,
		REG_ZONE_BOTTOM = 3'd3,
		REG_SHIFT_X     = 3'd4,
		REG_SHIFT_Y     = 3'd5,
		REG_RAMP_STEP   = 3'd6
	} reg_index_t;

	typedef struct packed {
		op_t                opcode;
		logic [PIX_W-1:0]   pixel_value;
		logic [COL_W-1:0]   column;
		logic [COL_W-1:0]   row;
		logic               frame_end;
	} item_t;

	typedef struct packed {
		logic               active;
		logic [LEVEL_W-1:0] intensity;
		logic               changed;
	} result_t;

endpackage

@@ hw/rtl/zar_stream_if.sv @@
interface zar_item_if import zar_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface zar_result_if import zar_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ hw/rtl/zar_cfg_regs.sv @@
module zar_cfg_regs import zar_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int CFG_W      = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	output logic [COORD_BITS-1:0] zone_left,
	output logic [COORD_BITS-1:0] zone_top,
	output logic [COORD_BITS-1:0] zone_right,
	output logic [COORD_BITS-1:0] zone_bottom,
	output logic [SHIFT_W-1:0]    shift_x,
	output logic [SHIFT_W-1:0]    shift_y,
	output logic [LEVEL_W-1:0]    ramp_step
);

	logic [COORD_BITS-1:0] zone_left_q, zone_top_q, zone_right_q, zone_bottom_q;
	logic [SHIFT_W-1:0]    shift_x_q, shift_y_q;
	logic [LEVEL_W-1:0]    ramp_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_left_q   <= '0;
			zone_top_q    <= '0;
			zone_right_q  <= '0;
			zone_bottom_q <= '0;
			shift_x_q     <= '0;
			shift_y_q     <= '0;
			ramp_step_q   <= RAMP_STEP_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ZONE_LEFT:   zone_left_q   <= cfg_data[COORD_BITS-1:0];
				REG_ZONE_TOP:    zone_top_q    <= cfg_data[COORD_BITS-1:0];
				REG_ZONE_RIGHT:  zone_right_q  <= cfg_data[COORD_BITS-1:0];
				REG_ZONE_BOTTOM: zone_bottom_q <= cfg_data[COORD_BITS-1:0];
				REG_SHIFT_X:     shift_x_q     <= cfg_data[SHIFT_W-1:0];
				REG_SHIFT_Y:     shift_y_q     <= cfg_data[SHIFT_W-1:0];
				REG_RAMP_STEP:   ramp_step_q   <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	assign zone_left   = zone_left_q;
	assign zone_top    = zone_top_q;
	assign zone_right  = zone_right_q;
	assign zone_bottom = zone_bottom_q;
	assign shift_x     = shift_x_q;
	assign shift_y     = shift_y_q;
	assign ramp_step   = ramp_step_q;

endmodule

@@ hw/rtl/zar_zone_test.sv @@
module zar_zone_test import zar_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  logic [PIX_W-1:0]      pixel_value,
	input  logic [COL_W-1:0]      column,
	input  logic [COL_W-1:0]      row,
	input  logic [SHIFT_W-1:0]    shift_x,
	input  logic [SHIFT_W-1:0]    shift_y,
	input  logic [COORD_BITS-1:0] zone_left,
	input  logic [COORD_BITS-1:0] zone_top,
	input  logic [COORD_BITS-1:0] zone_right,
	input  logic [COORD_BITS-1:0] zone_bottom,
	output logic                  hit
);

	localparam int SUM_W = COL_W + 1;
	localparam int CMP_W = (COORD_BITS > SUM_W) ? COORD_BITS : SUM_W;

	logic [SUM_W-1:0] x_sum, y_sum;
	logic [CMP_W-1:0] x, y, left, top, right, bottom;

	// shifted position keeps its carry, no wrap
	assign x_sum = SUM_W'(column) + SUM_W'(shift_x);
	assign y_sum = SUM_W'(row) + SUM_W'(shift_y);

	assign x      = CMP_W'(x_sum);
	assign y      = CMP_W'(y_sum);
	assign left   = CMP_W'(zone_left);
	assign top    = CMP_W'(zone_top);
	assign right  = CMP_W'(zone_right);
	assign bottom = CMP_W'(zone_bottom);

	assign hit = (pixel_value == ACTIVE_VALUE) && (x > left) && (x < right)
		&& (y > top) && (y < bottom);

endmodule

@@ hw/rtl/zar_core.sv @@
module zar_core import zar_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  item_t              item_s1,
	input  logic               hit,
	input  logic [LEVEL_W-1:0] ramp_step,
	output result_t            result
);

	logic               frame_hit_q, zone_active_q;
	logic [LEVEL_W-1:0] level_q;
	logic               frame_hit_d, zone_active_d, changed_d;
	logic [LEVEL_W-1:0] level_d;
	logic [LEVEL_W:0]   up_sum;
	result_t            result_s2;

	assign up_sum = {1'b0, level_q} + {1'b0, ramp_step};

	always_comb begin
		frame_hit_d   = frame_hit_q;
		zone_active_d = zone_active_q;
		level_d       = level_q;
		changed_d     = 1'b0;
		case (item_s1.opcode)
			OP_PIXEL: begin
				frame_hit_d = frame_hit_q | hit;
				if (item_s1.frame_end) begin
					zone_active_d = frame_hit_d;
					frame_hit_d   = 1'b0;
				end
			end
			OP_TICK: begin
				if (zone_active_q) begin
					level_d = up_sum[LEVEL_W] ? LEVEL_MAX : up_sum[LEVEL_W-1:0];
				end else begin
					level_d = (level_q > ramp_step) ? level_q - ramp_step : '0;
				end
				changed_d = (level_d != level_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_hit_q   <= 1'b0;
			zone_active_q <= 1'b0;
			level_q       <= LEVEL_RESET;
		end else if (advance) begin
			frame_hit_q   <= frame_hit_d;
			zone_active_q <= zone_active_d;
			level_q       <= level_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= '{active: zone_active_d, intensity: level_d, changed: changed_d};
		end
	end

	assign result = result_s2;

endmodule

@@ hw/rtl/zone_activity_intensity_ramp.sv @@
// zone activity intensity ramp
//
// item channel: activity-map pixels (opcode pixel) with column, row and a
// frame_end mark on the last pixel, and intensity ticks (opcode tick).
// result channel: one result per item with the zone activity flag, the
// ramped 8-bit intensity and a changed flag that only ticks can raise.
// configuration: cfg_wr_en / cfg_index / cfg_data write the zone bounds, the
// position shifts and ramp step; the user must write while idle, not enforced.
//
// throughput: one item per cycle while the result is not stalled. latency: two
// register stages; the item transfer loads the input register, and the result
// register loads from it through the zone compare and ramp logic when it is free.
// a stalled result holds in the result register while the input register
// still takes one more item; item.ready drops only when both are full.
// reset clears both registers' valid bits, the frame hit mark, the zone
// flag and the intensity, and loads the configuration defaults (ramp step 15).
module zone_activity_intensity_ramp import zar_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	zar_item_if.sink                                      item,
	zar_result_if.source                                  result,
	input  logic                                          cfg_wr_en,
	input  logic [REG_IDX_W-1:0]                          cfg_index,
	input  logic [((COORD_BITS > SHIFT_W) ? COORD_BITS : SHIFT_W)-1:0] cfg_data
);

	localparam int CFG_W = (COORD_BITS > SHIFT_W) ? COORD_BITS : SHIFT_W;

	logic [COORD_BITS-1:0] zone_left, zone_top, zone_right, zone_bottom;
	logic [SHIFT_W-1:0]    shift_x, shift_y;
	logic [LEVEL_W-1:0]    ramp_step;

	item_t   item_s1;
	logic    valid_s1;
	logic    res_valid_q;
	logic    out_free, advance, hit;
	result_t res_data;

	zar_cfg_regs #(.COORD_BITS(COORD_BITS), .CFG_W(CFG_W)) u_cfg (
		.clk, .arst_n, .cfg_wr_en, .cfg_index, .cfg_data,
		.zone_left, .zone_top, .zone_right, .zone_bottom,
		.shift_x, .shift_y, .ramp_step
	);

	assign out_free   = !res_valid_q || result.ready;
	assign advance    = valid_s1 && out_free;
	assign item.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (item.ready) valid_s1 <= item.valid;
			if (out_free) res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) item_s1 <= item.data;
	end

	zar_zone_test #(.COORD_BITS(COORD_BITS)) u_zone (
		.pixel_value(item_s1.pixel_value),
		.column(item_s1.column),
		.row(item_s1.row),
		.shift_x, .shift_y,
		.zone_left, .zone_top, .zone_right, .zone_bottom,
		.hit
	);

	zar_core u_core (
		.clk, .arst_n, .advance, .item_s1, .hit, .ramp_step,
		.result(res_data)
	);

	assign result.valid = res_valid_q;
	assign result.data  = res_data;

endmodule

@@ hw/rtl/zar_checker.sv @@
module zar_checker import zar_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_ready,
	input logic               res_valid,
	input logic               res_ready,
	input logic [LEVEL_W-1:0] res_intensity,
	input logic               res_changed
);

	logic [1:0]         pending_q;
	logic [LEVEL_W-1:0] last_level_q;
	logic               in_xfer, out_xfer;

	assign in_xfer  = item_valid && item_ready;
	assign out_xfer = res_valid && res_ready;

	// items taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= 2'd0;
			last_level_q <= LEVEL_RESET;
		end else begin
			pending_q <= pending_q + 2'(in_xfer) - 2'(out_xfer);
			if (out_xfer) last_level_q <= res_intensity;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pending_q != 2'd0)
		else $error("result shown with no item outstanding");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more items outstanding than the pipeline holds");

	a_still: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && !res_changed |-> res_intensity == last_level_q)
		else $error("intensity moved without changed flag");

	a_moved: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && res_changed |-> res_intensity != last_level_q)
		else $error("changed flag set but intensity held");

endmodule

bind zone_activity_intensity_ramp zar_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.item_valid(item.valid),
	.item_ready(item.ready),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.res_intensity(result.data.intensity),
	.res_changed(result.data.changed)
);
